[rtl/core/rrt_pkg.sv]
// Shared types, constants and microcode for the RR tachogram resampler.
// Used by every module in rtl/core; depends on nothing.

package rrt_pkg;

  // Field and datapath widths
  localparam int RrW     = 12;
  localparam int PeriodW = 12;
  localparam int TimeW   = 32;
  localparam int RateW   = 24;
  localparam int DistW   = 13;
  localparam int ProdW   = RrW + RateW;
  localparam int PcW     = 4;

  // Rate numerator: 60000 ms/min * 256 (Q.8)
  localparam logic [RateW-1:0]   RATE_NUM     = 24'd15360000;
  localparam logic [PeriodW-1:0] PERIOD_RESET = 12'd250;
  localparam logic [PeriodW-1:0] PERIOD_MIN   = 12'd64;

  // Datapath operations, applied when a step completes
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH_RR,
    OP_DIV_RATE,
    OP_ADVANCE,
    OP_MUL,
    OP_DIV_INTERP,
    OP_EMIT_SAMPLE,
    OP_EMIT_BAD,
    OP_EMIT_FIRST
  } op_t;

  // What a step waits on before it completes
  typedef enum logic [2:0] {
    W_NONE,
    W_IN,
    W_DIV,
    W_OUT,
    W_DIV_OUT
  } wait_t;

  // Jump conditions; when false the step counter advances by one
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_RR_ZERO,
    C_NOT_STARTED,
    C_D_GT_RR
  } cond_t;

  // Step addresses
  localparam logic [PcW-1:0] PC_FETCH = 4'd0;
  localparam logic [PcW-1:0] PC_CHECK = 4'd1;
  localparam logic [PcW-1:0] PC_RATE  = 4'd2;
  localparam logic [PcW-1:0] PC_RWAIT = 4'd3;
  localparam logic [PcW-1:0] PC_ADV   = 4'd4;
  localparam logic [PcW-1:0] PC_TEST  = 4'd5;
  localparam logic [PcW-1:0] PC_MUL   = 4'd6;
  localparam logic [PcW-1:0] PC_DIVI  = 4'd7;
  localparam logic [PcW-1:0] PC_EMIT  = 4'd8;
  localparam logic [PcW-1:0] PC_BAD   = 4'd9;
  localparam logic [PcW-1:0] PC_FIRST = 4'd10;

  typedef struct packed {
    wait_t          wt;
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_free;
    logic rr_zero;
    logic started;
    logic d_gt_rr;
  } seq_stat_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t  op;
    logic fire;
  } seq_ctrl_t;

  // Control store
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t uw;
    case (pc)
      PC_FETCH: uw = '{W_IN,      OP_LATCH_RR,    C_NEXT,        PC_FETCH};
      PC_CHECK: uw = '{W_NONE,    OP_NOP,         C_RR_ZERO,     PC_BAD};
      PC_RATE:  uw = '{W_NONE,    OP_DIV_RATE,    C_NEXT,        PC_FETCH};
      PC_RWAIT: uw = '{W_DIV,     OP_NOP,         C_NOT_STARTED, PC_FIRST};
      PC_ADV:   uw = '{W_NONE,    OP_ADVANCE,     C_NEXT,        PC_FETCH};
      PC_TEST:  uw = '{W_NONE,    OP_NOP,         C_D_GT_RR,     PC_FETCH};
      PC_MUL:   uw = '{W_NONE,    OP_MUL,         C_NEXT,        PC_FETCH};
      PC_DIVI:  uw = '{W_NONE,    OP_DIV_INTERP,  C_NEXT,        PC_FETCH};
      PC_EMIT:  uw = '{W_DIV_OUT, OP_EMIT_SAMPLE, C_ALWAYS,      PC_TEST};
      PC_BAD:   uw = '{W_OUT,     OP_EMIT_BAD,    C_ALWAYS,      PC_FETCH};
      PC_FIRST: uw = '{W_OUT,     OP_EMIT_FIRST,  C_ALWAYS,      PC_FETCH};
      default:  uw = '{W_NONE,    OP_NOP,         C_ALWAYS,      PC_FETCH};
    endcase
    return uw;
  endfunction

endpackage

[rtl/core/rrt_in_if.sv]
// Input channel carrying one RR interval per request.
// Depends on rrt_pkg for the field width.

interface rrt_in_if;
  logic                     valid;
  logic                     ready;
  logic [rrt_pkg::RrW-1:0] rr_ms;

  modport source (output valid, output rr_ms, input ready);
  modport sink   (input valid, input rr_ms, output ready);
endinterface

[rtl/core/rrt_out_if.sv]
// Output channel carrying one resampled heart-rate sample per request.
// Depends on rrt_pkg for the field widths.

interface rrt_out_if;
  logic                       valid;
  logic                       ready;
  logic [rrt_pkg::TimeW-1:0] sample_time_ms;
  logic [rrt_pkg::RateW-1:0] rate_bpm_q8;
  logic                       last_of_run;
  logic                       bad_interval;

  modport source (output valid, output sample_time_ms, output rate_bpm_q8,
                  output last_of_run, output bad_interval, input ready);
  modport sink   (input valid, input sample_time_ms, input rate_bpm_q8,
                  input last_of_run, input bad_interval, output ready);
endinterface

[rtl/core/rrt_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on rrt_pkg; the dividend's high part must be below the divisor.

module rrt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rrt_pkg::ProdW-1:0]   num,
  input  logic [rrt_pkg::RrW-1:0]     den,
  output logic                        busy,
  output logic [rrt_pkg::RateW-1:0]   quot
);

  localparam int CntW = $clog2(rrt_pkg::RateW);

  logic [rrt_pkg::RrW-1:0]   rem;
  logic [rrt_pkg::RateW-1:0] qsh;
  logic [CntW-1:0]           cnt;
  logic                      busy_r;

  logic [rrt_pkg::RrW:0]     trial;
  logic [rrt_pkg::RrW:0]     diff;
  logic                      ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, qsh[rrt_pkg::RateW-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  // Control: load on start, count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt    <= CntW'(rrt_pkg::RateW - 1);
    end else if (busy_r) begin
      if (cnt == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[rrt_pkg::ProdW-1:rrt_pkg::RateW];
      qsh <= num[rrt_pkg::RateW-1:0];
    end else if (busy_r) begin
      rem <= ge ? diff[rrt_pkg::RrW-1:0] : trial[rrt_pkg::RrW-1:0];
      qsh <= {qsh[rrt_pkg::RateW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = qsh;

endmodule

[rtl/core/rrt_seq.sv]
// Microcoded sequencer: step counter, control store lookup, waits and jumps.
// Depends on rrt_pkg for the control word, status and control structs.

module rrt_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  rrt_pkg::seq_stat_t   stat,
  output rrt_pkg::seq_ctrl_t   ctrl
);

  logic [rrt_pkg::PcW-1:0] pc;
  logic [rrt_pkg::PcW-1:0] pc_next;
  rrt_pkg::uword_t         uw;
  logic                    wait_ok;
  logic                    taken;

  // Decode the current step
  always_comb begin
    uw = rrt_pkg::ucode(pc);

    case (uw.wt)
      rrt_pkg::W_NONE:    wait_ok = 1'b1;
      rrt_pkg::W_IN:      wait_ok = stat.in_valid;
      rrt_pkg::W_DIV:     wait_ok = !stat.div_busy;
      rrt_pkg::W_OUT:     wait_ok = stat.out_free;
      rrt_pkg::W_DIV_OUT: wait_ok = !stat.div_busy && stat.out_free;
      default:            wait_ok = 1'b1;
    endcase

    case (uw.cond)
      rrt_pkg::C_NEXT:        taken = 1'b0;
      rrt_pkg::C_ALWAYS:      taken = 1'b1;
      rrt_pkg::C_RR_ZERO:     taken = stat.rr_zero;
      rrt_pkg::C_NOT_STARTED: taken = !stat.started;
      rrt_pkg::C_D_GT_RR:     taken = stat.d_gt_rr;
      default:                taken = 1'b0;
    endcase

    if (!wait_ok) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 1'b1;
    end

    ctrl.op   = uw.op;
    ctrl.fire = wait_ok;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rrt_pkg::PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[rtl/core/rr_tachogram_resampler.sv]
// RR tachogram resampler: top level with datapath, sequencer and divider.
// Depends on rrt_pkg, rrt_in_if, rrt_out_if, rrt_div and rrt_seq.
//
// Usage:
//   rr_in carries one RR interval (ms) per request. smp_out carries the
//   resampled heart rate (bpm, Q.8) at each grid time, with last_of_run set
//   on the final sample of an interval, or a single bad_interval sample for
//   a zero interval. cfg_we/cfg_data write the grid period in ms; values
//   below 64 act as 64. Write it only while the block is idle.
// Operation:
//   A microcoded sequencer drives one shared radix-2 divider. A zero
//   interval yields one bad_interval sample; any other has its rate
//   divided out, then yields a first-beat sample or steps through its
//   grid samples (compare, multiply, divide, emit), at most 64 of them.
//   The next interval is taken only after the last sample is emitted.
// Reset:
//   rst (synchronous) sets the period to 250 ms, clears the start flag and
//   empties the output register. The next nonzero interval sets time 0.
// Backpressure:
//   A result waits in the output register while smp_out.ready is low; the
//   sequencer holds at its next emit step until that register frees.

module rr_tachogram_resampler (
  input  logic                          clk,
  input  logic                          rst,
  rrt_in_if.sink                        rr_in,
  rrt_out_if.source                     smp_out,
  input  logic                          cfg_we,
  input  logic [rrt_pkg::PeriodW-1:0]   cfg_data
);

  // Configuration and beat state
  logic [rrt_pkg::PeriodW-1:0] period_reg;
  logic [rrt_pkg::PeriodW-1:0] period;
  logic                        started;
  logic [rrt_pkg::RrW-1:0]     rr;
  logic [rrt_pkg::RateW-1:0]   prev_rate;
  logic [rrt_pkg::RateW-1:0]   beat_rate;
  logic [rrt_pkg::TimeW-1:0]   beat_time;
  logic [rrt_pkg::TimeW-1:0]   next_grid;
  logic [rrt_pkg::DistW-1:0]   d;
  logic [rrt_pkg::ProdW-1:0]   prod_a;
  logic [rrt_pkg::ProdW-1:0]   prod_b;

  // Output register
  logic                        out_valid;
  logic [rrt_pkg::TimeW-1:0]   out_time;
  logic [rrt_pkg::RateW-1:0]   out_rate;
  logic                        out_last;
  logic                        out_bad;
  logic                        out_free;

  // Sequencer and divider hookup
  rrt_pkg::seq_stat_t          stat;
  rrt_pkg::seq_ctrl_t          ctrl;
  logic                        div_start;
  logic [rrt_pkg::ProdW-1:0]   div_num;
  logic                        div_busy;
  logic [rrt_pkg::RateW-1:0]   quot;

  logic [rrt_pkg::RrW-1:0]     rr_minus_d;
  logic                        last_next;

  // Clamp the period and form the per-step helpers
  always_comb begin
    period     = (period_reg < rrt_pkg::PERIOD_MIN) ? rrt_pkg::PERIOD_MIN : period_reg;
    rr_minus_d = rrt_pkg::RrW'({1'b0, rr} - d);
    last_next  = (({1'b0, d} + {2'b00, period}) > {2'b00, rr});
    out_free   = !out_valid || smp_out.ready;
    div_start  = ctrl.fire &&
                 (ctrl.op == rrt_pkg::OP_DIV_RATE || ctrl.op == rrt_pkg::OP_DIV_INTERP);
    div_num    = (ctrl.op == rrt_pkg::OP_DIV_RATE) ?
                 {{rrt_pkg::RrW{1'b0}}, rrt_pkg::RATE_NUM} : (prod_a + prod_b);
  end

  // Status to the sequencer
  always_comb begin
    stat.in_valid = rr_in.valid;
    stat.div_busy = div_busy;
    stat.out_free = out_free;
    stat.rr_zero  = (rr == '0);
    stat.started  = started;
    stat.d_gt_rr  = (d > {1'b0, rr});
  end

  assign rr_in.ready = (ctrl.op == rrt_pkg::OP_LATCH_RR);

  rrt_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (rr),
    .busy  (div_busy),
    .quot  (quot)
  );

  // Hold the period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg <= rrt_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_reg <= cfg_data;
    end
  end

  // Start flag
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (ctrl.fire && ctrl.op == rrt_pkg::OP_EMIT_FIRST) begin
      started <= 1'b1;
    end
  end

  // Execute the datapath operation of the completing step
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.op)
        rrt_pkg::OP_LATCH_RR: begin
          rr <= rr_in.rr_ms;
        end
        rrt_pkg::OP_ADVANCE: begin
          prev_rate <= beat_rate;
          beat_rate <= quot;
          d         <= rrt_pkg::DistW'(next_grid - beat_time);
          beat_time <= beat_time + {{(rrt_pkg::TimeW-rrt_pkg::RrW){1'b0}}, rr};
        end
        rrt_pkg::OP_MUL: begin
          prod_a <= rrt_pkg::ProdW'(prev_rate) * rrt_pkg::ProdW'(rr_minus_d);
          prod_b <= rrt_pkg::ProdW'(beat_rate) * rrt_pkg::ProdW'(d);
        end
        rrt_pkg::OP_EMIT_SAMPLE: begin
          next_grid <= next_grid + {{(rrt_pkg::TimeW-rrt_pkg::PeriodW){1'b0}}, period};
          d         <= d + {1'b0, period};
        end
        rrt_pkg::OP_EMIT_FIRST: begin
          prev_rate <= '0;
          beat_rate <= quot;
          beat_time <= '0;
          next_grid <= {{(rrt_pkg::TimeW-rrt_pkg::PeriodW){1'b0}}, period};
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load on emit, drop on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && (ctrl.op == rrt_pkg::OP_EMIT_SAMPLE ||
                               ctrl.op == rrt_pkg::OP_EMIT_BAD ||
                               ctrl.op == rrt_pkg::OP_EMIT_FIRST)) begin
      out_valid <= 1'b1;
    end else if (smp_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.op)
        rrt_pkg::OP_EMIT_SAMPLE: begin
          out_time <= next_grid;
          out_rate <= quot;
          out_last <= last_next;
          out_bad  <= 1'b0;
        end
        rrt_pkg::OP_EMIT_BAD: begin
          out_time <= '0;
          out_rate <= '0;
          out_last <= 1'b0;
          out_bad  <= 1'b1;
        end
        rrt_pkg::OP_EMIT_FIRST: begin
          out_time <= '0;
          out_rate <= quot;
          out_last <= 1'b1;
          out_bad  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign smp_out.valid          = out_valid;
  assign smp_out.sample_time_ms = out_time;
  assign smp_out.rate_bpm_q8    = out_rate;
  assign smp_out.last_of_run    = out_last;
  assign smp_out.bad_interval   = out_bad;

endmodule

[dv/rrt_sample_checker.sv]
`timescale 1ns / 1ps
// Sample checker for the RR tachogram resampler: watches the interval and sample
// channels and the period register, predicts every sample and compares in order.
// Depends on rrt_pkg, rrt_in_if and rrt_out_if.

module rrt_sample_checker (
  input  logic                        clk,
  input  logic                        rst,
  rrt_in_if                           rr_ch,
  rrt_out_if                          smp_ch,
  input  logic                        cfg_we,
  input  logic [rrt_pkg::PeriodW-1:0] cfg_data,
  output int                          outstanding,
  output int                          fail_count
);

  localparam int MaxRun    = 64;
  localparam int MaxPrint  = 40;
  localparam int WantDepth = 128;
  localparam int TimeW     = rrt_pkg::TimeW;
  localparam int RateW     = rrt_pkg::RateW;
  localparam int RrW       = rrt_pkg::RrW;
  localparam int PeriodW   = rrt_pkg::PeriodW;

  typedef struct {
    logic [TimeW-1:0] t_ms;
    logic [RateW-1:0] rate;
    logic             last;
    logic             bad;
  } hr_sample_t;

  hr_sample_t         want_mem [WantDepth];
  int                 want_wr = 0;
  int                 want_rd = 0;
  logic [PeriodW-1:0] period_reg;
  logic               beat_seen;
  logic [TimeW-1:0]   beat_t;
  logic [RateW-1:0]   beat_rate;
  logic [TimeW-1:0]   grid_due;
  int                 mismatches = 0;

  assign fail_count = mismatches;

  function automatic hr_sample_t sample_of(input logic [TimeW-1:0] t_ms,
                                           input logic [RateW-1:0] rate,
                                           input logic last, input logic bad);
    hr_sample_t s;
    s.t_ms = t_ms;
    s.rate = rate;
    s.last = last;
    s.bad  = bad;
    return s;
  endfunction

  // Append one prediction to the ring of expected samples
  function automatic void enqueue_want(input hr_sample_t s);
    want_mem[want_wr % WantDepth] = s;
    want_wr++;
  endfunction

  // Predict the grid samples that one interval produces and queue them
  function automatic void resample_interval(input logic [RrW-1:0] rr);
    logic [TimeW-1:0] step_ms;
    logic [TimeW-1:0] prior_t;
    logic [TimeW-1:0] ofs;
    logic [TimeW-1:0] rr_w;
    logic [RateW-1:0] rate;
    logic [RateW-1:0] prior_rate;
    logic [RateW-1:0] y;
    logic [63:0]      acc;
    int               n;
    step_ms = (period_reg < rrt_pkg::PERIOD_MIN) ? TimeW'(rrt_pkg::PERIOD_MIN) :
                                                   TimeW'(period_reg);
    rr_w    = TimeW'(rr);
    // zero interval: flag it, keep the beat state
    if (rr == '0) begin
      enqueue_want(sample_of('0, '0, 1'b0, 1'b1));
      return;
    end
    rate = rrt_pkg::RATE_NUM / RateW'(rr);
    // first beat: set the time origin and emit its rate at time zero
    if (!beat_seen) begin
      beat_seen = 1'b1;
      beat_t    = '0;
      beat_rate = rate;
      grid_due  = step_ms;
      enqueue_want(sample_of('0, rate, 1'b1, 1'b0));
      return;
    end
    prior_t    = beat_t;
    prior_rate = beat_rate;
    beat_t     = beat_t + rr_w;
    beat_rate  = rate;
    // walk the grid through (previous beat, this beat]
    ofs = grid_due - prior_t;
    n   = 0;
    while (ofs <= rr_w && n < MaxRun) begin
      if (ofs == rr_w) begin
        y = rate;
      end else begin
        acc = 64'(prior_rate) * 64'(rr_w - ofs) + 64'(rate) * 64'(ofs);
        y   = RateW'(acc / 64'(rr_w));
      end
      enqueue_want(sample_of(grid_due, y,
                             (ofs + step_ms > rr_w) || (n == MaxRun - 1), 1'b0));
      n++;
      grid_due = grid_due + step_ms;
      ofs      = ofs + step_ms;
    end
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < MaxPrint) $display("[%0t] sample check: %s", $time, what);
    mismatches++;
  endtask

  // Compare one accepted sample against the oldest prediction
  task automatic check_sample();
    hr_sample_t want;
    if (want_wr == want_rd) begin
      note_mismatch($sformatf("unexpected sample t=%0d rate=%0d last=%0b bad=%0b",
                              smp_ch.sample_time_ms, smp_ch.rate_bpm_q8,
                              smp_ch.last_of_run, smp_ch.bad_interval));
      return;
    end
    want = want_mem[want_rd % WantDepth];
    want_rd++;
    if (smp_ch.sample_time_ms !== want.t_ms)
      note_mismatch($sformatf("sample_time_ms got %0d want %0d",
                              smp_ch.sample_time_ms, want.t_ms));
    if (smp_ch.rate_bpm_q8 !== want.rate)
      note_mismatch($sformatf("rate_bpm_q8 got %0d want %0d at t=%0d",
                              smp_ch.rate_bpm_q8, want.rate, want.t_ms));
    if (smp_ch.last_of_run !== want.last)
      note_mismatch($sformatf("last_of_run got %0b want %0b at t=%0d",
                              smp_ch.last_of_run, want.last, want.t_ms));
    if (smp_ch.bad_interval !== want.bad)
      note_mismatch($sformatf("bad_interval got %0b want %0b at t=%0d",
                              smp_ch.bad_interval, want.bad, want.t_ms));
  endtask

  // Check samples first, then predict for the request taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      want_wr    = 0;
      want_rd    = 0;
      period_reg = rrt_pkg::PERIOD_RESET;
      beat_seen  = 1'b0;
      beat_t     = '0;
      beat_rate  = '0;
      grid_due   = '0;
    end else begin
      if (smp_ch.valid && smp_ch.ready) check_sample();
      if (rr_ch.valid && rr_ch.ready) resample_interval(rr_ch.rr_ms);
      if (cfg_we) period_reg = cfg_data;
    end
    outstanding <= want_wr - want_rd;
  end

endmodule

[dv/tb_rr_tachogram_resampler.sv]
`timescale 1ns / 1ps
// Testbench top for the RR tachogram resampler: clock, reset, interval stimulus,
// sample backpressure and period writes. Depends on rrt_pkg, both channel
// interfaces, the resampler and rrt_sample_checker.

module tb_rr_tachogram_resampler;

  localparam int SettleCycles = 64;
  localparam int StallLimit   = 3000;
  localparam int PhaseItems   = 25;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [rrt_pkg::PeriodW-1:0] cfg_data;
  int                          outstanding;
  int                          fail_count;
  bit                          calm;
  int                          rx_hold;
  int                          rx_draw;
  int                          quiet_cycles;
  int unsigned                 opening [0:13] = '{0, 4095, 250, 100, 1, 4095, 0, 149,
                                                  2730, 1365, 2047, 2048, 64, 3};
  int unsigned                 periods [0:7]  = '{64, 4095, 0, 0, 250, 0, 1000, 63};

  rrt_in_if  rr_if ();
  rrt_out_if smp_if ();

  rr_tachogram_resampler dut (
    .clk      (clk),
    .rst      (rst),
    .rr_in    (rr_if),
    .smp_out  (smp_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rrt_sample_checker chk (
    .clk         (clk),
    .rst         (rst),
    .rr_ch       (rr_if),
    .smp_ch      (smp_if),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Pace sample acceptance: after each taken sample, hold ready low for a gap from draw_gap (none while calm)
  always @(posedge clk) begin
    if (rst) begin
      smp_if.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (smp_if.ready && smp_if.valid) begin
      rx_draw = draw_gap();
      smp_if.ready <= (rx_draw == 0);
      rx_hold      <= rx_draw - 1;
    end else if (!smp_if.ready) begin
      if (rx_hold <= 0) smp_if.ready <= 1'b1;
      else rx_hold <= rx_hold - 1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (rr_if.valid && rr_if.ready) || (smp_if.valid && smp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one interval after a random gap and hold it until taken
  task automatic send_rr(input int unsigned rr);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      rr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rr_if.valid <= 1'b1;
    rr_if.rr_ms <= rrt_pkg::RrW'(rr);
    do @(posedge clk); while (!rr_if.ready);
  endtask

  // Wait for every predicted sample, then let the sequencer go idle
  task automatic drain_and_settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_period(input int unsigned ms);
    rr_if.valid <= 1'b0;
    drain_and_settle();
    cfg_we   <= 1'b1;
    cfg_data <= rrt_pkg::PeriodW'(ms);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly plausible heartbeats, with zeros, tiny and full-range intervals
  function automatic int unsigned pick_rr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 12) return $urandom_range(1, 63);
    if (r < 25) return $urandom_range(1, 4095);
    if (r < 29) return (r[0]) ? 4095 : 1;
    return $urandom_range(300, 2000);
  endfunction

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    rr_if.valid  <= 1'b0;
    rr_if.rr_ms  <= '0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero before the first beat, first beat, exact hit, empty span, extremes
    foreach (opening[i]) send_rr(opening[i]);

    // shortest grid with the longest interval
    set_period(rrt_pkg::PERIOD_MIN);
    send_rr(4095);
    send_rr(4095);
    send_rr(64);

    // period below the floor acts as the floor
    set_period(0);
    send_rr(1);
    send_rr(63);
    send_rr(128);

    // widest grid
    set_period(4095);
    send_rr(4095);
    send_rr(4095);

    set_period(63);
    send_rr(700);

    // random phases, each under its own period
    periods[2] = $urandom_range(0, 4095);
    periods[5] = $urandom_range(64, 4095);
    foreach (periods[p]) begin
      set_period(periods[p]);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 14 == 0) calm = ($urandom_range(0, 3) == 0);
        send_rr(pick_rr());
      end
    end

    rr_if.valid <= 1'b0;
    drain_and_settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rrt_pkg.sv
rtl/core/rrt_in_if.sv
rtl/core/rrt_out_if.sv
rtl/core/rrt_div.sv
rtl/core/rrt_seq.sv
rtl/core/rr_tachogram_resampler.sv
dv/rrt_sample_checker.sv
dv/tb_rr_tachogram_resampler.sv
